// File: sv/candid_header_type_table_checker_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the header type table checker
// Clocked, reset-gated wrappers for same-cycle and next-cycle implications.
// ----------------------------------------------------------------------------
`ifndef CANDID_HEADER_TYPE_TABLE_CHECKER_UNIT_MACROS_SVH
`define CANDID_HEADER_TYPE_TABLE_CHECKER_UNIT_MACROS_SVH

// cons must hold in the same cycle as ante
`define CTHC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define CTHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cthc_pkg.sv
// ----------------------------------------------------------------------------
// cthc_pkg
// Types, codes and constants shared by the header type table checker.
// ----------------------------------------------------------------------------
package cthc_pkg;

  localparam int MAX_ENTRIES   = 16384;
  localparam int ENTRY_W       = $clog2(MAX_ENTRIES);
  localparam int LEB_MAX_BYTES = 10;
  localparam int LIMIT_W       = 15;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd16384;

  // type codes as 64-bit two's complement values
  localparam logic [63:0] T_OPT = 64'hFFFF_FFFF_FFFF_FFEE;
  localparam logic [63:0] T_VEC = 64'hFFFF_FFFF_FFFF_FFED;
  localparam logic [63:0] T_REC = 64'hFFFF_FFFF_FFFF_FFEC;
  localparam logic [63:0] T_VAR = 64'hFFFF_FFFF_FFFF_FFEB;
  localparam logic [63:0] T_MIN = 64'hFFFF_FFFF_FFFF_FFE8;

  typedef enum logic [3:0] {
    PH_MAGIC, PH_TSIZE, PH_CODE, PH_REF, PH_COUNT,
    PH_HASH, PH_FTYPE, PH_ARGC, PH_PAYLOAD, PH_ERROR
  } phase_t;

  typedef enum logic [3:0] {
    ST_BUSY    = 4'd0,
    ST_OK      = 4'd1,
    ST_PAYLOAD = 4'd2,
    ST_TRUNC   = 4'd3,
    ST_MAGIC   = 4'd4,
    ST_RANGE   = 4'd5,
    ST_TYPE    = 4'd6,
    ST_OVF     = 4'd7,
    ST_AFTER   = 4'd8
  } status_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [63:0] acc;
    logic [3:0]  cnt;
    logic [63:0] value;
  } leb_res_t;

  typedef struct packed {
    status_t     status;
    logic [13:0] table_size;
    logic [15:0] byte_offset;
    logic        in_error;
  } fsm_out_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0: b = 8'h44;
      2'd1: b = 8'h49;
      2'd2: b = 8'h44;
      default: b = 8'h4C;
    endcase
    return b;
  endfunction

endpackage

// File: sv/cthc_leb.sv
// ----------------------------------------------------------------------------
// cthc_leb
// One byte step of the (S)LEB128 decoder: accumulate, detect end and overflow.
// ----------------------------------------------------------------------------
module cthc_leb (
  input  logic [63:0]        acc_i,
  input  logic [3:0]         cnt_i,
  input  logic [7:0]         byte_i,
  input  logic               sgn_i,
  output cthc_pkg::leb_res_t res_o
);

  logic [6:0]  shamt;
  logic [6:0]  shamt_next;
  logic [3:0]  cnt_new;
  logic [63:0] contrib;
  logic [63:0] acc_new;
  logic [63:0] sext;

  assign shamt      = 7'(cnt_i) * 7'd7;
  assign cnt_new    = cnt_i + 4'd1;
  assign shamt_next = 7'(cnt_new) * 7'd7;

  // bits beyond 63 fall off
  assign contrib = (shamt < 7'd64) ? ({57'd0, byte_i[6:0]} << shamt[5:0]) : 64'd0;
  assign acc_new = acc_i | contrib;

  // sign extension from bit 6 of the final byte
  assign sext = (sgn_i && byte_i[6] && shamt_next < 7'd64) ?
                (~64'd0 << shamt_next[5:0]) : 64'd0;

  always_comb begin
    res_o.acc   = acc_new;
    res_o.cnt   = cnt_new;
    res_o.done  = !byte_i[7];
    res_o.ovf   = byte_i[7] && (cnt_new >= 4'(cthc_pkg::LEB_MAX_BYTES));
    res_o.value = acc_new | sext;
  end

endmodule

// File: sv/cthc_hdr_fsm.sv
// ----------------------------------------------------------------------------
// cthc_hdr_fsm
// Frame state and per-byte header parsing: magic, table size, entries, argc.
// ----------------------------------------------------------------------------
module cthc_hdr_fsm (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step_i,
  input  logic [7:0]                          byte_i,
  input  logic                                last_i,
  input  logic [cthc_pkg::LIMIT_W-1:0]        table_limit_i,
  output cthc_pkg::fsm_out_t                  res_o
);

  localparam int EW = cthc_pkg::ENTRY_W;

  cthc_pkg::phase_t  phase_r,  phase_nxt;
  logic [1:0]        magic_r,  magic_nxt;
  logic [63:0]       acc_r,    acc_nxt;
  logic [3:0]        cnt_r,    cnt_nxt;
  logic [EW-1:0]     total_r,  total_nxt;
  logic [EW-1:0]     done_r,   done_nxt;
  logic [63:0]       fields_r, fields_nxt;
  logic [63:0]       hash_r,   hash_nxt;
  logic              hvld_r,   hvld_nxt;
  logic [15:0]       offset_r, offset_nxt;

  cthc_pkg::leb_res_t leb;
  cthc_pkg::status_t  st;
  logic               sgn;
  logic [63:0]        v;
  logic               type_ok;
  logic [EW:0]        done_inc;
  cthc_pkg::phase_t   after_entry;
  logic [63:0]        fields_dec;

  assign sgn = (phase_r == cthc_pkg::PH_CODE) || (phase_r == cthc_pkg::PH_REF) ||
               (phase_r == cthc_pkg::PH_FTYPE);

  cthc_leb u_leb (
    .acc_i  (acc_r),
    .cnt_i  (cnt_r),
    .byte_i (byte_i),
    .sgn_i  (sgn),
    .res_o  (leb)
  );

  assign v          = leb.value;
  assign type_ok    = v[63] ? (v >= cthc_pkg::T_MIN) : (v <= 64'(total_r));
  assign done_inc   = {1'b0, done_r} + (EW+1)'(1);
  assign after_entry = (done_inc >= {1'b0, total_r}) ? cthc_pkg::PH_ARGC
                                                     : cthc_pkg::PH_CODE;
  assign fields_dec = fields_r - 64'd1;

  always_comb begin
    st         = cthc_pkg::ST_BUSY;
    phase_nxt  = phase_r;
    magic_nxt  = magic_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    total_nxt  = total_r;
    done_nxt   = done_r;
    fields_nxt = fields_r;
    hash_nxt   = hash_r;
    hvld_nxt   = hvld_r;
    offset_nxt = offset_r + 16'd1;

    unique case (phase_r)
      cthc_pkg::PH_ERROR:   st = cthc_pkg::ST_AFTER;
      cthc_pkg::PH_PAYLOAD: st = cthc_pkg::ST_PAYLOAD;
      cthc_pkg::PH_MAGIC: begin
        if (byte_i != cthc_pkg::magic_byte(magic_r)) begin
          phase_nxt = cthc_pkg::PH_ERROR;
          st        = cthc_pkg::ST_MAGIC;
        end else begin
          magic_nxt = magic_r + 2'd1;
          if (magic_r == 2'd3) phase_nxt = cthc_pkg::PH_TSIZE;
        end
      end
      default: begin
        acc_nxt = leb.acc;
        cnt_nxt = leb.cnt;
        if (leb.ovf) begin
          phase_nxt = cthc_pkg::PH_ERROR;
          st        = cthc_pkg::ST_OVF;
        end else if (leb.done) begin
          acc_nxt = 64'd0;
          cnt_nxt = 4'd0;
          if (sgn && !type_ok) begin
            phase_nxt = cthc_pkg::PH_ERROR;
            st        = cthc_pkg::ST_RANGE;
          end else begin
            unique case (phase_r)
              cthc_pkg::PH_TSIZE: begin
                if (v >= 64'(table_limit_i) || v >= 64'(cthc_pkg::MAX_ENTRIES)) begin
                  phase_nxt = cthc_pkg::PH_ERROR;
                  st        = cthc_pkg::ST_RANGE;
                end else begin
                  total_nxt = v[EW-1:0];
                  phase_nxt = (v == 64'd0) ? cthc_pkg::PH_ARGC : cthc_pkg::PH_CODE;
                end
              end
              cthc_pkg::PH_CODE: begin
                if (v == cthc_pkg::T_OPT || v == cthc_pkg::T_VEC) begin
                  phase_nxt = cthc_pkg::PH_REF;
                end else if (v == cthc_pkg::T_REC || v == cthc_pkg::T_VAR) begin
                  phase_nxt = cthc_pkg::PH_COUNT;
                end else begin
                  phase_nxt = cthc_pkg::PH_ERROR;
                  st        = cthc_pkg::ST_TYPE;
                end
              end
              cthc_pkg::PH_REF: begin
                done_nxt  = done_inc[EW-1:0];
                phase_nxt = after_entry;
              end
              cthc_pkg::PH_COUNT: begin
                fields_nxt = v;
                hash_nxt   = 64'd0;
                hvld_nxt   = 1'b0;
                if (v == 64'd0) begin
                  done_nxt  = done_inc[EW-1:0];
                  phase_nxt = after_entry;
                end else begin
                  phase_nxt = cthc_pkg::PH_HASH;
                end
              end
              cthc_pkg::PH_HASH: begin
                if (hvld_r && v <= hash_r) begin
                  phase_nxt = cthc_pkg::PH_ERROR;
                  st        = cthc_pkg::ST_RANGE;
                end else begin
                  hash_nxt  = v;
                  hvld_nxt  = 1'b1;
                  phase_nxt = cthc_pkg::PH_FTYPE;
                end
              end
              cthc_pkg::PH_FTYPE: begin
                fields_nxt = fields_dec;
                if (fields_dec == 64'd0) begin
                  done_nxt  = done_inc[EW-1:0];
                  phase_nxt = after_entry;
                end else begin
                  phase_nxt = cthc_pkg::PH_HASH;
                end
              end
              default: begin
                if (v != 64'd1) begin
                  phase_nxt = cthc_pkg::PH_ERROR;
                  st        = cthc_pkg::ST_RANGE;
                end else begin
                  phase_nxt = cthc_pkg::PH_PAYLOAD;
                  st        = cthc_pkg::ST_OK;
                end
              end
            endcase
          end
        end
      end
    endcase

    res_o.status      = (last_i && st == cthc_pkg::ST_BUSY) ? cthc_pkg::ST_TRUNC : st;
    res_o.table_size  = 14'(done_nxt);
    res_o.byte_offset = offset_r;
    res_o.in_error    = (phase_r == cthc_pkg::PH_ERROR);

    // end of frame: back to a fresh frame
    if (last_i) begin
      phase_nxt  = cthc_pkg::PH_MAGIC;
      magic_nxt  = 2'd0;
      acc_nxt    = 64'd0;
      cnt_nxt    = 4'd0;
      total_nxt  = '0;
      done_nxt   = '0;
      fields_nxt = 64'd0;
      hash_nxt   = 64'd0;
      hvld_nxt   = 1'b0;
      offset_nxt = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= cthc_pkg::PH_MAGIC;
      magic_r  <= 2'd0;
      acc_r    <= 64'd0;
      cnt_r    <= 4'd0;
      total_r  <= '0;
      done_r   <= '0;
      fields_r <= 64'd0;
      hash_r   <= 64'd0;
      hvld_r   <= 1'b0;
      offset_r <= 16'd0;
    end else if (step_i) begin
      phase_r  <= phase_nxt;
      magic_r  <= magic_nxt;
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      total_r  <= total_nxt;
      done_r   <= done_nxt;
      fields_r <= fields_nxt;
      hash_r   <= hash_nxt;
      hvld_r   <= hvld_nxt;
      offset_r <= offset_nxt;
    end
  end

endmodule

// File: sv/candid_header_type_table_checker_unit.sv
// ----------------------------------------------------------------------------
// candid_header_type_table_checker_unit
// Byte-stream checker for a serialized message header and its type table.
//
//   channel | dir | payload                                  | transfer when
//   --------+-----+------------------------------------------+----------------
//   in_     | in  | tdata=data_byte, tlast=last_byte         | tvalid & tready
//   out_    | out | tdata=status, table_size, byte_offset    | tvalid & tready
//   cfg_    | in  | wr_data=table_limit                      | wr_en
//
// One byte per cycle sustained while out_tready holds; each byte gives exactly one result.
// A byte passes through the input stage register, then the result register.
// The frame state update sits between those two registers in a single pass.
// Reset (synchronous, rst_n low) empties both stages, clears the frame state
// and sets table_limit to 16384.
// A stalled result holds; an empty input stage still takes one more byte, then
// in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`include "candid_header_type_table_checker_unit_macros.svh"

module candid_header_type_table_checker_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] data_byte
  input  logic                         in_tlast,   // last_byte
  // result channel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [39:0]                  out_tdata,  // [3:0] status, [17:4] table_size,
                                                   // [33:18] byte_offset, [39:34] zero
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [cthc_pkg::LIMIT_W-1:0] cfg_wr_data // table_limit
);

  // table size limit register
  logic [cthc_pkg::LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= cthc_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // input stage
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       advance;

  // a byte moves on when the result register is free or being emptied
  assign advance   = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // parser: frame state is stepped once per byte leaving the input stage
  cthc_pkg::fsm_out_t fsm_out;

  cthc_hdr_fsm u_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_i        (advance),
    .byte_i        (in_byte_r),
    .last_i        (in_last_r),
    .table_limit_i (limit_r),
    .res_o         (fsm_out)
  );

  // result register
  logic        out_valid_r;
  logic [39:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {6'd0, fsm_out.byte_offset, fsm_out.table_size,
                     4'(fsm_out.status)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `CTHC_ASSERT_NEXT(a_stage_hold, clk, rst_n, in_valid_r && !advance, in_valid_r && $stable(in_byte_r) && $stable(in_last_r), "input stage lost a stalled byte")
  `CTHC_ASSERT_SAME(a_ready_empty, clk, rst_n, !in_valid_r, in_tready, "empty input stage refused a transfer")
  `CTHC_ASSERT_SAME(a_err_latch, clk, rst_n, advance && fsm_out.in_error, fsm_out.status == cthc_pkg::ST_AFTER, "latched error did not report after-error")
  `CTHC_ASSERT_NEXT(a_result_shown, clk, rst_n, advance, out_tvalid, "processed byte gave no result")

endmodule
